@@ src/optimal_page_replacement_top_macros.svh @@
// assertion macros for the optimal page replacement block
// used by the port checker, no other dependencies
`ifndef OPTIMAL_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define OPTIMAL_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define OPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/opr_pkg.sv @@
// shared types and constants for the optimal page replacement block
// no dependencies
`timescale 1ns / 1ps

package opr_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam int unsigned MaxLengthDef = 64;
  localparam int unsigned PageBitsDef  = 8;

  // register indexes, one word each
  localparam logic RegFrameCount = 1'b0;

  localparam logic [4:0] FrameCountReset = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } opr_state_e;

  typedef struct packed {
    logic store;
    logic lookup;
    logic scan_init;
    logic scan_step;
    logic commit;
  } opr_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic scan_done;
    logic last_ref;
  } opr_sts_t;

endpackage

@@ src/optimal_page_replacement_top.sv @@
// top level of the optimal (farthest next use) page replacement block
// depends on opr_pkg, opr_regs, opr_ctrl, opr_dp
`timescale 1ns / 1ps

// channel   | handshake                             | word
// ----------+---------------------------------------+----------------------------------
// input     | start && !busy                        | page_number_i, is_last_i
// result    | result_valid_o, one cycle, no stall   | position_o .. end_of_run_o
// config    | psel && penable && pwrite (pready=1)  | paddr[2] index, pwdata value
//
// a word without is_last is only stored and leaves busy low; the last word
// starts a run that emits one result per stored reference, then busy drops
// a reference that hits or fills a free frame goes through fetch, lookup and
// commit; a miss with all frames full adds a lookahead over the later entries,
// one string entry a cycle through the single read port of the memory, ending
// early once every frame's next use is found
// each result shows on the ports the cycle after its commit
// reset clears counters and sets frame_count to 4; the string and the frames
// hold no reset value and are only read where written during a run

module optimal_page_replacement_top import opr_pkg::*; #(
  parameter int unsigned NUM_FRAMES = MaxFramesDef,
  parameter int unsigned MAX_LENGTH = MaxLengthDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  page_number_i,
  input  logic        is_last_i,
  // result channel
  output logic        result_valid_o,
  output logic [5:0]  position_o,
  output logic [7:0]  page_out_o,
  output logic        was_fault_o,
  output logic [3:0]  slot_o,
  output logic [6:0]  faults_so_far_o,
  output logic        end_of_run_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  opr_cmd_t   cmd;
  opr_sts_t   sts;
  logic [4:0] frame_count;

  // frame_count register
  opr_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_count_o (frame_count)
  );

  // sequencer: idle/load, then per reference fetch, lookup, scan (full misses only), commit
  opr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .is_last_i (is_last_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // string memory, frame lanes, scan and result register
  opr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .MAX_LENGTH (MAX_LENGTH),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_count_i   (frame_count),
    .page_number_i   (page_number_i),
    .result_valid_o  (result_valid_o),
    .position_o      (position_o),
    .page_out_o      (page_out_o),
    .was_fault_o     (was_fault_o),
    .slot_o          (slot_o),
    .faults_so_far_o (faults_so_far_o),
    .end_of_run_o    (end_of_run_o)
  );

endmodule

@@ src/opr_regs.sv @@
// apb register file holding frame_count
// depends on opr_pkg
`timescale 1ns / 1ps

module opr_regs import opr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  frame_count_o
);

  logic [4:0] frame_count_q;
  logic       reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == RegFrameCount);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
    end else if (wr_en) begin
      frame_count_q <= pwdata[4:0];
    end
  end

  assign prdata        = (reg_idx == RegFrameCount) ? 32'(frame_count_q) : '0;
  assign frame_count_o = frame_count_q;

endmodule

@@ src/opr_ctrl.sv @@
// sequencing state machine: load, lookup, victim scan, commit
// depends on opr_pkg
`timescale 1ns / 1ps

module opr_ctrl import opr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     is_last_i,
  input  opr_sts_t sts_i,
  output opr_cmd_t cmd_o,
  output logic     busy_o
);

  opr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && is_last_i) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts_i.hit || !sts_i.full) state_d = ST_COMMIT;
        else                          state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.last_ref) state_d = ST_IDLE;
        else                state_d = ST_FETCH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.store = start_i;
      end
      ST_FETCH: begin
      end
      ST_LOOKUP: begin
        cmd_o.lookup    = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

@@ src/opr_dp.sv @@
// datapath: reference string memory, frame lanes, lookahead scan, result word
// depends on opr_pkg
`timescale 1ns / 1ps

module opr_dp import opr_pkg::*; #(
  parameter int unsigned NUM_FRAMES = MaxFramesDef,
  parameter int unsigned MAX_LENGTH = MaxLengthDef,
  parameter int unsigned PAGE_BITS  = PageBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  opr_cmd_t   cmd_i,
  output opr_sts_t   sts_o,
  input  logic [4:0] frame_count_i,
  input  logic [7:0] page_number_i,
  output logic       result_valid_o,
  output logic [5:0] position_o,
  output logic [7:0] page_out_o,
  output logic       was_fault_o,
  output logic [3:0] slot_o,
  output logic [6:0] faults_so_far_o,
  output logic       end_of_run_o
);

  localparam int unsigned AW = $clog2(MAX_LENGTH);
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned NW = $clog2(NUM_FRAMES + 1);

  // reference string memory
  logic [PAGE_BITS-1:0] mem [MAX_LENGTH];
  logic [PAGE_BITS-1:0] rd_q;
  logic [AW-1:0]        rd_addr;
  logic [15:0]          page_ext;
  logic [PAGE_BITS-1:0] page_in;
  logic                 mem_we;

  logic [CW-1:0] count_q;
  logic [AW-1:0] pos_q;
  logic [CW-1:0] k_q;
  logic          cmpv_q;

  logic [PAGE_BITS-1:0] frames_q [NUM_FRAMES];
  logic [NW-1:0]        fill_q;
  logic [CW-1:0]        faults_q;
  logic [NW-1:0]        cap;

  logic [PAGE_BITS-1:0] cur_page_q;
  logic                 hit_q;
  logic [FW-1:0]        hit_slot_q;

  logic [NUM_FRAMES-1:0] seen_q, seen_d, seen_init;
  logic [FW-1:0]         last_q, last_d;

  logic [NUM_FRAMES-1:0] match;
  logic                  hit;
  logic [FW-1:0]         hit_slot;
  logic                  full;
  logic                  all_seen;
  logic [FW-1:0]         first_unseen;
  logic [FW-1:0]         victim;
  logic [FW-1:0]         slot_sel;
  logic                  k_live;
  logic                  last_ref;
  logic [CW-1:0]         faults_next;

  logic       res_valid_q;
  logic [5:0] res_pos_q;
  logic [7:0] res_page_q;
  logic       res_fault_q;
  logic [3:0] res_slot_q;
  logic [6:0] res_faults_q;
  logic       res_end_q;

  logic [15:0] cur_page_ext;
  logic [7:0]  slot_ext;
  logic [7:0]  faults_ext;

  assign page_ext = 16'(page_number_i);
  assign page_in  = page_ext[PAGE_BITS-1:0];
  assign mem_we   = cmd_i.store && (count_q < CW'(MAX_LENGTH));
  assign rd_addr  = cmd_i.scan_step ? k_q[AW-1:0] : pos_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= page_in;
    end
    rd_q <= mem[rd_addr];
  end

  // active frame count, zero acts as one, above NUM_FRAMES clamps to NUM_FRAMES
  always_comb begin
    if (frame_count_i == 5'd0) begin
      cap = NW'(1);
    end else if (7'(frame_count_i) > 7'(NUM_FRAMES)) begin
      cap = NW'(NUM_FRAMES);
    end else begin
      cap = NW'(frame_count_i);
    end
  end

  // parallel lookup over filled lanes
  always_comb begin
    hit_slot = '0;
    for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
      match[j] = (NW'(j) < fill_q) && (frames_q[j] == rd_q);
      if (match[j]) hit_slot = FW'(j);
    end
  end
  assign hit  = |match;
  assign full = (fill_q >= cap);

  // lanes beyond the active count never take part in the scan
  always_comb begin
    for (int j = 0; j < NUM_FRAMES; j++) begin
      seen_init[j] = (NW'(j) >= cap);
    end
  end

  assign k_live   = (k_q < count_q);
  assign all_seen = &seen_q;

  always_comb begin
    seen_d = seen_q;
    last_d = last_q;
    if (cmpv_q) begin
      for (int j = 0; j < NUM_FRAMES; j++) begin
        if (!seen_q[j] && (frames_q[j] == rd_q)) begin
          seen_d[j] = 1'b1;
          last_d    = FW'(j);
        end
      end
    end
  end

  always_comb begin
    first_unseen = '0;
    for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
      if (!seen_q[j]) first_unseen = FW'(j);
    end
  end
  assign victim = all_seen ? last_q : first_unseen;

  always_comb begin
    if (hit_q)      slot_sel = hit_slot_q;
    else if (!full) slot_sel = fill_q[FW-1:0];
    else            slot_sel = victim;
  end

  assign last_ref    = ((CW'(pos_q) + CW'(1)) == count_q);
  assign faults_next = hit_q ? faults_q : (faults_q + CW'(1));

  assign sts_o.hit       = hit;
  assign sts_o.full      = full;
  assign sts_o.scan_done = all_seen || (!cmpv_q && !k_live);
  assign sts_o.last_ref  = last_ref;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      faults_q    <= '0;
      cmpv_q      <= 1'b0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.commit;
      if (mem_we) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_init) begin
        k_q    <= CW'(pos_q) + CW'(1);
        cmpv_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmpv_q <= k_live;
        if (k_live) k_q <= k_q + CW'(1);
      end
      if (cmd_i.commit) begin
        if (last_ref) begin
          count_q  <= '0;
          pos_q    <= '0;
          fill_q   <= '0;
          faults_q <= '0;
        end else begin
          pos_q    <= pos_q + AW'(1);
          faults_q <= faults_next;
          if (!hit_q && !full) fill_q <= fill_q + NW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      cur_page_q <= rd_q;
      hit_q      <= hit;
      hit_slot_q <= hit_slot;
    end
    if (cmd_i.scan_init) begin
      seen_q <= seen_init;
      last_q <= '0;
    end else if (cmd_i.scan_step) begin
      seen_q <= seen_d;
      last_q <= last_d;
    end
    for (int j = 0; j < NUM_FRAMES; j++) begin
      if (cmd_i.commit && !hit_q && (slot_sel == FW'(j))) begin
        frames_q[j] <= cur_page_q;
      end
    end
    if (cmd_i.commit) begin
      res_pos_q    <= 6'(pos_q);
      res_page_q   <= cur_page_ext[7:0];
      res_fault_q  <= !hit_q;
      res_slot_q   <= slot_ext[3:0];
      res_faults_q <= faults_ext[6:0];
      res_end_q    <= last_ref;
    end
  end

  assign cur_page_ext = 16'(cur_page_q);
  assign slot_ext     = 8'(slot_sel);
  assign faults_ext   = 8'(faults_next);

  assign result_valid_o  = res_valid_q;
  assign position_o      = res_pos_q;
  assign page_out_o      = res_page_q;
  assign was_fault_o     = res_fault_q;
  assign slot_o          = res_slot_q;
  assign faults_so_far_o = res_faults_q;
  assign end_of_run_o    = res_end_q;

endmodule

@@ src/opr_sva_chk.sv @@
// port-level assertions for the optimal page replacement block, with bind
// depends on optimal_page_replacement_top_macros.svh
`timescale 1ns / 1ps
`include "optimal_page_replacement_top_macros.svh"

module opr_sva_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       is_last_i,
  input logic       result_valid_o,
  input logic       end_of_run_o,
  input logic [6:0] faults_so_far_o
);

  // a last word always launches a run
  `OPR_ASSERT_NEXT(a_last_starts_run, clk_i, rst_ni, start && !busy && is_last_i, busy, "last word did not start a run")

  // a word that is not last is only stored
  `OPR_ASSERT_NEXT(a_load_is_silent, clk_i, rst_ni, start && !busy && !is_last_i, !busy && !result_valid_o, "non-last word caused activity")

  // results inside a run come while busy, and the first reference always faults
  `OPR_ASSERT_NOW(a_mid_run_busy, clk_i, rst_ni, result_valid_o && !end_of_run_o, busy && (faults_so_far_o != 7'd0), "result outside a run or with no fault counted")

  // run ends cleanly
  `OPR_ASSERT_NEXT(a_end_quiet, clk_i, rst_ni, result_valid_o && end_of_run_o, !result_valid_o, "result after end of run")

endmodule

bind optimal_page_replacement_top opr_sva_chk u_opr_sva_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .is_last_i       (is_last_i),
  .result_valid_o  (result_valid_o),
  .end_of_run_o    (end_of_run_o),
  .faults_so_far_o (faults_so_far_o)
);
